// ===== sv/sva_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the synth voice allocator.
// No dependencies; imported by the allocator top level and its checker.
package sva_pkg;

    localparam logic [1:0] KIND_ON   = 2'd0;
    localparam logic [1:0] KIND_OFF  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam int NOTE_W  = 7;
    localparam int TAG_W   = 16;
    localparam int VEL_W   = 7;
    localparam int AGE_W   = 64;
    localparam int SLOT_W  = 4;
    localparam int MASK_W  = 16;
    localparam int COUNT_W = 5;

    typedef struct packed {
        logic [AGE_W-1:0]  age;
        logic [TAG_W-1:0]  ident;
        logic [VEL_W-1:0]  velocity;
        logic [NOTE_W-1:0] note;
    } voice_rec_t;

    localparam int REC_W = $bits(voice_rec_t);

endpackage

// ===== sv/sva_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module sva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/synth_voice_allocator.sv =====
`timescale 1ns / 1ps
// Voice allocator: one word is in flight at a time and s_ready is high only when idle.
// A finished, ignored or bend word goes straight to the finish state, and a note on that
// finds a free voice writes the voice RAM first. A note off scans the voice RAM before it
// finishes, and a note on that must steal scans it and then writes; both scans walk
// the voice RAM one voice per cycle through a single comparator. The result word
// is valid from the cycle s_ready rises, and a result still waiting for m_ready holds
// the next word's result and s_ready back until it is taken.
// Active and held bits live in flops, the note/tag/velocity/age records in a RAM.
// Depends on sva_pkg and sva_ram.
module synth_voice_allocator import sva_pkg::*; #(
    parameter int NUM_VOICES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [NOTE_W-1:0]  s_note,
    input  logic [TAG_W-1:0]   s_voice_tag,
    input  logic [VEL_W-1:0]   s_velocity,
    input  logic               s_bend_update,
    input  logic [SLOT_W-1:0]  s_finished_slot,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [SLOT_W-1:0]  m_slot,
    output logic               m_allocated,
    output logic               m_stolen,
    output logic [MASK_W-1:0]  m_release_mask,
    output logic [COUNT_W-1:0] m_active_count
);

    localparam int IW  = $clog2(NUM_VOICES);
    localparam int CW  = $clog2(NUM_VOICES + 1);
    localparam int SW  = (IW > SLOT_W) ? IW : SLOT_W;
    localparam int CPW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int RW  = (NUM_VOICES > MASK_W) ? NUM_VOICES : MASK_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_WRITE  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic MODE_STEAL   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    logic [1:0]            state_reg, state_next;
    logic                  mode_reg, mode_next;
    logic [NUM_VOICES-1:0] active_reg, active_next;
    logic [NUM_VOICES-1:0] held_reg, held_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AGE_W-1:0]      counter_reg, counter_next;
    logic [IW:0]           cnt_reg, cnt_next;
    logic                  pend_reg, pend_next;
    logic [IW-1:0]         pidx_reg, pidx_next;
    logic                  m_valid_reg, m_valid_next;

    logic [NOTE_W-1:0]     note_reg, note_next;
    logic [TAG_W-1:0]      tag_reg, tag_next;
    logic [VEL_W-1:0]      vel_reg, vel_next;
    logic [AGE_W-1:0]      best_age_reg, best_age_next;
    logic [IW-1:0]         best_idx_reg, best_idx_next;
    logic [IW-1:0]         slot_reg, slot_next;
    logic                  alloc_reg, alloc_next;
    logic                  stolen_reg, stolen_next;
    logic [RW-1:0]         rel_reg, rel_next;
    logic [SLOT_W-1:0]     out_slot_reg, out_slot_next;
    logic                  out_alloc_reg, out_alloc_next;
    logic                  out_stolen_reg, out_stolen_next;
    logic [MASK_W-1:0]     out_rel_reg, out_rel_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;

    logic                  free_any;
    logic [IW-1:0]         free_idx;
    logic                  fin_hit;
    logic [NUM_VOICES-1:0] fin_vec;
    logic                  ram_we, ram_re;
    logic [IW-1:0]         ram_raddr;
    voice_rec_t            ram_wdata, ram_rdata;
    logic [SW-1:0]         slot_pad;
    logic [CPW-1:0]        count_pad;

    sva_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_VOICES)
    ) u_voice_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // lowest free voice
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int v = NUM_VOICES - 1; v >= 0; v--) begin
            if (!active_reg[v]) begin
                free_any = 1'b1;
                free_idx = IW'(v);
            end
        end
    end

    always_comb begin
        fin_vec = '0;
        for (int v = 0; v < NUM_VOICES; v++) begin
            fin_vec[v] = (32'(s_finished_slot) == v) && active_reg[v];
        end
        fin_hit = |fin_vec;
    end

    assign slot_pad  = SW'(slot_reg);
    assign count_pad = CPW'(count_reg);

    assign ram_wdata.age      = counter_reg + AGE_W'(1);
    assign ram_wdata.ident    = tag_reg;
    assign ram_wdata.velocity = vel_reg;
    assign ram_wdata.note     = note_reg;
    assign ram_raddr          = cnt_reg[IW-1:0];

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        active_next     = active_reg;
        held_next       = held_reg;
        count_next      = count_reg;
        counter_next    = counter_reg;
        cnt_next        = cnt_reg;
        pend_next       = 1'b0;
        pidx_next       = pidx_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        note_next       = note_reg;
        tag_next        = tag_reg;
        vel_next        = vel_reg;
        best_age_next   = best_age_reg;
        best_idx_next   = best_idx_reg;
        slot_next       = slot_reg;
        alloc_next      = alloc_reg;
        stolen_next     = stolen_reg;
        rel_next        = rel_reg;
        out_slot_next   = out_slot_reg;
        out_alloc_next  = out_alloc_reg;
        out_stolen_next = out_stolen_reg;
        out_rel_next    = out_rel_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    note_next     = s_note;
                    tag_next      = s_voice_tag;
                    vel_next      = s_velocity;
                    slot_next     = '0;
                    alloc_next    = 1'b0;
                    stolen_next   = 1'b0;
                    rel_next      = '0;
                    best_age_next = '1;
                    best_idx_next = '0;
                    cnt_next      = '0;
                    state_next    = ST_FINISH;
                    if (s_kind == KIND_ON && s_velocity != '0) begin
                        alloc_next = 1'b1;
                        if (free_any) begin
                            slot_next  = free_idx;
                            state_next = ST_WRITE;
                        end else begin
                            stolen_next = 1'b1;
                            mode_next   = MODE_STEAL;
                            state_next  = ST_SCAN;
                        end
                    end else if (s_kind == KIND_OFF && !s_bend_update) begin
                        mode_next  = MODE_RELEASE;
                        state_next = ST_SCAN;
                    end else if (s_kind == KIND_DONE && fin_hit) begin
                        active_next = active_reg & ~fin_vec;
                        count_next  = count_reg - CW'(1);
                    end
                end
            end
            ST_SCAN: begin
                if (32'(cnt_reg) < NUM_VOICES) begin
                    ram_re    = 1'b1;
                    cnt_next  = cnt_reg + (IW+1)'(1);
                    pend_next = 1'b1;
                    pidx_next = cnt_reg[IW-1:0];
                end
                if (pend_reg) begin
                    if (mode_reg == MODE_STEAL) begin
                        if (ram_rdata.age < best_age_reg) begin
                            best_age_next = ram_rdata.age;
                            best_idx_next = pidx_reg;
                        end
                    end else if (active_reg[pidx_reg] && held_reg[pidx_reg] &&
                                 (ram_rdata.ident == tag_reg ||
                                  ram_rdata.note == note_reg)) begin
                        held_next[pidx_reg] = 1'b0;
                        rel_next[pidx_reg]  = 1'b1;
                    end
                end else if (32'(cnt_reg) >= NUM_VOICES) begin
                    if (mode_reg == MODE_STEAL) begin
                        slot_next  = best_idx_reg;
                        state_next = ST_WRITE;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_WRITE: begin
                ram_we                = 1'b1;
                active_next[slot_reg] = 1'b1;
                held_next[slot_reg]   = 1'b1;
                counter_next          = counter_reg + AGE_W'(1);
                if (!stolen_reg) begin
                    count_next = count_reg + CW'(1);
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    out_slot_next   = slot_pad[SLOT_W-1:0];
                    out_alloc_next  = alloc_reg;
                    out_stolen_next = stolen_reg;
                    out_rel_next    = rel_reg[MASK_W-1:0];
                    out_count_next  = count_pad[COUNT_W-1:0];
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_STEAL;
            active_reg  <= '0;
            held_reg    <= '0;
            count_reg   <= '0;
            counter_reg <= '0;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            pidx_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            active_reg  <= active_next;
            held_reg    <= held_next;
            count_reg   <= count_next;
            counter_reg <= counter_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            pidx_reg    <= pidx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        note_reg       <= note_next;
        tag_reg        <= tag_next;
        vel_reg        <= vel_next;
        best_age_reg   <= best_age_next;
        best_idx_reg   <= best_idx_next;
        slot_reg       <= slot_next;
        alloc_reg      <= alloc_next;
        stolen_reg     <= stolen_next;
        rel_reg        <= rel_next;
        out_slot_reg   <= out_slot_next;
        out_alloc_reg  <= out_alloc_next;
        out_stolen_reg <= out_stolen_next;
        out_rel_reg    <= out_rel_next;
        out_count_reg  <= out_count_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_slot         = out_slot_reg;
    assign m_allocated    = out_alloc_reg;
    assign m_stolen       = out_stolen_reg;
    assign m_release_mask = out_rel_reg;
    assign m_active_count = out_count_reg;

endmodule

// ===== sv/sva_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for synth_voice_allocator, attached by bind.
// Depends on sva_pkg and the allocator top level.
module sva_checker import sva_pkg::*; #(
    parameter int NUM_VOICES = 16
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [SLOT_W-1:0]  m_slot,
    input logic               m_allocated,
    input logic               m_stolen,
    input logic [MASK_W-1:0]  m_release_mask,
    input logic [COUNT_W-1:0] m_active_count
);

    a_stolen_implies_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stolen |-> m_allocated)
        else $error("stolen word without allocation");

    a_steal_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stolen |-> m_active_count == COUNT_W'(NUM_VOICES))
        else $error("steal reported with free voices");

    a_release_excludes_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_release_mask != '0 |-> !m_allocated)
        else $error("release and allocation in one word");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while busy");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_slot) && $stable(m_release_mask))
        else $error("result word changed while stalled");

endmodule

bind synth_voice_allocator sva_checker #(
    .NUM_VOICES (NUM_VOICES)
) u_sva_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_slot         (m_slot),
    .m_allocated    (m_allocated),
    .m_stolen       (m_stolen),
    .m_release_mask (m_release_mask),
    .m_active_count (m_active_count)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for synth_voice_allocator: directed voice-table cases, then
// random note traffic. Results are checked against an in-bench voice table model.
// Depends on sva_pkg and the allocator RTL.
module tb import sva_pkg::*; ();

    localparam int NUM_VOICES = 16;
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = NUM_VOICES + 10;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               allocated;
        logic               stolen;
        logic [MASK_W-1:0]  release_mask;
        logic [COUNT_W-1:0] active_count;
    } alloc_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_kind = KIND_SPARE;
    logic [NOTE_W-1:0]  s_note = '0;
    logic [TAG_W-1:0]   s_voice_tag = '0;
    logic [VEL_W-1:0]   s_velocity = '0;
    logic               s_bend_update = 1'b0;
    logic [SLOT_W-1:0]  s_finished_slot = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [SLOT_W-1:0]  m_slot;
    logic               m_allocated;
    logic               m_stolen;
    logic [MASK_W-1:0]  m_release_mask;
    logic [COUNT_W-1:0] m_active_count;

    // voice table mirror
    logic               voice_on [NUM_VOICES];
    logic               voice_held [NUM_VOICES];
    logic [NOTE_W-1:0]  voice_note [NUM_VOICES];
    logic [TAG_W-1:0]   voice_ident [NUM_VOICES];
    logic [VEL_W-1:0]   voice_vel [NUM_VOICES];
    logic [AGE_W-1:0]   voice_age [NUM_VOICES];
    logic [AGE_W-1:0]   stamp_counter;

    alloc_result_t pending_results[$];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    bit            steady_flow = 1'b0;

    synth_voice_allocator #(
        .NUM_VOICES(NUM_VOICES)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_note          (s_note),
        .s_voice_tag     (s_voice_tag),
        .s_velocity      (s_velocity),
        .s_bend_update   (s_bend_update),
        .s_finished_slot (s_finished_slot),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_slot          (m_slot),
        .m_allocated     (m_allocated),
        .m_stolen        (m_stolen),
        .m_release_mask  (m_release_mask),
        .m_active_count  (m_active_count)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 13);
    end

    function automatic alloc_result_t allocate_event(input logic [1:0] kind,
                                                     input logic [NOTE_W-1:0] note,
                                                     input logic [TAG_W-1:0] tag,
                                                     input logic [VEL_W-1:0] vel,
                                                     input logic bend,
                                                     input logic [SLOT_W-1:0] fin);
        alloc_result_t   r;
        int              pick;
        int              live;
        logic [AGE_W-1:0] oldest;
        r = '0;
        pick = -1;
        live = 0;
        case (kind)
            KIND_ON: begin
                if (vel != '0) begin
                    for (int v = 0; v < NUM_VOICES; v++)
                        if (!voice_on[v] && pick < 0)
                            pick = v;
                    if (pick < 0) begin
                        // all busy: steal the oldest stamp, lowest index on a tie
                        pick = 0;
                        oldest = '1;
                        for (int v = 0; v < NUM_VOICES; v++) begin
                            if (voice_age[v] < oldest) begin
                                oldest = voice_age[v];
                                pick = v;
                            end
                        end
                        r.stolen = 1'b1;
                    end
                    stamp_counter = stamp_counter + AGE_W'(1);
                    voice_on[pick] = 1'b1;
                    voice_held[pick] = 1'b1;
                    voice_note[pick] = note;
                    voice_ident[pick] = tag;
                    voice_vel[pick] = vel;
                    voice_age[pick] = stamp_counter;
                    r.slot = pick[SLOT_W-1:0];
                    r.allocated = 1'b1;
                end
            end
            KIND_OFF: begin
                if (!bend) begin
                    for (int v = 0; v < NUM_VOICES; v++) begin
                        if (voice_on[v] && voice_held[v] &&
                            (voice_ident[v] == tag || voice_note[v] == note)) begin
                            voice_held[v] = 1'b0;
                            r.release_mask[v] = 1'b1;
                        end
                    end
                end
            end
            KIND_DONE: begin
                if (fin < NUM_VOICES)
                    voice_on[fin] = 1'b0;
            end
            default: ;
        endcase
        for (int v = 0; v < NUM_VOICES; v++)
            if (voice_on[v])
                live++;
        r.active_count = live[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        alloc_result_t got;
        alloc_result_t want;
        got = '{m_slot, m_allocated, m_stolen, m_release_mask, m_active_count};
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected word: slot=%0d alloc=%0b stolen=%0b mask=%h count=%0d",
                             got.slot, got.allocated, got.stolen, got.release_mask,
                             got.active_count);
            end else begin
                want = pending_results.pop_front();
                if (got.slot !== want.slot || got.allocated !== want.allocated ||
                    got.stolen !== want.stolen || got.release_mask !== want.release_mask ||
                    got.active_count !== want.active_count) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: exp slot=%0d alloc=%0b stolen=%0b mask=%h ",
                                 want.slot, want.allocated, want.stolen,
                                 want.release_mask,
                                 "count=%0d, got slot=%0d alloc=%0b stolen=%0b ",
                                 want.active_count, got.slot, got.allocated,
                                 got.stolen, "mask=%h count=%0d",
                                 got.release_mask, got.active_count);
                end
            end
        end
    end

    // drives one word from a falling edge; valid stays up until the next call, pause or drain
    task automatic send_word(input logic [1:0] kind, input logic [NOTE_W-1:0] note,
                             input logic [TAG_W-1:0] tag, input logic [VEL_W-1:0] vel,
                             input logic bend, input logic [SLOT_W-1:0] fin);
        alloc_result_t expected;
        @(negedge aclk);
        while (!steady_flow && $urandom_range(99) < 13) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_kind <= kind;
        s_note <= note;
        s_voice_tag <= tag;
        s_velocity <= vel;
        s_bend_update <= bend;
        s_finished_slot <= fin;
        s_valid <= 1'b1;
        do
            @(posedge aclk);
        while (!s_ready);
        expected = allocate_event(kind, note, tag, vel, bend, fin);
        pending_results = {pending_results, expected};
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic test_ignored_words();
        send_word(KIND_SPARE, '1, '1, '1, 1'b1, '1);
        send_word(KIND_ON, 7'd64, 16'h0040, 7'd0, 1'b0, 4'd0);
        send_word(KIND_OFF, 7'd0, 16'h0000, 7'd0, 1'b0, 4'd0);
        send_word(KIND_DONE, 7'd0, 16'h0000, 7'd0, 1'b0, 4'd15);
    endtask

    task automatic test_fill_and_steal();
        send_word(KIND_ON, 7'd127, 16'hFFFF, 7'd127, 1'b1, 4'd0);
        send_word(KIND_ON, 7'd0, 16'h0000, 7'd1, 1'b0, 4'd0);
        for (int i = 2; i < NUM_VOICES; i++)
            send_word(KIND_ON, 7'(40 + i), 16'(100 + i), 7'($urandom_range(1, 127)),
                      1'b0, 4'd0);
        send_word(KIND_ON, 7'd60, 16'h1234, 7'd90, 1'b0, 4'd0);
        send_word(KIND_ON, 7'd61, 16'h1234, 7'd91, 1'b0, 4'd0);
    endtask

    task automatic test_release_and_finish();
        send_word(KIND_OFF, 7'd60, 16'h1234, 7'd0, 1'b1, 4'd0);
        send_word(KIND_OFF, 7'd0, 16'h1234, 7'd0, 1'b0, 4'd0);
        send_word(KIND_OFF, 7'd45, 16'h0007, 7'd0, 1'b0, 4'd0);
        send_word(KIND_DONE, 7'd0, 16'h0000, 7'd0, 1'b0, 4'd3);
        send_word(KIND_DONE, 7'd0, 16'h0000, 7'd0, 1'b0, 4'd3);
        send_word(KIND_OFF, 7'd43, 16'h0000, 7'd0, 1'b0, 4'd0);
        send_word(KIND_ON, 7'd72, 16'hA5A5, 7'd64, 1'b0, 4'd0);
    endtask

    task automatic test_random_traffic(input int count);
        int            sent;
        int            pick;
        logic [1:0]    kind;
        logic [NOTE_W-1:0] note;
        logic [TAG_W-1:0]  tag;
        logic [VEL_W-1:0]  vel;
        logic          bend;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            kind = pick < 45 ? KIND_ON : pick < 70 ? KIND_OFF : pick < 95 ? KIND_DONE
                                                                            : KIND_SPARE;
            // small note and tag pools so note offs actually match held voices
            note = ($urandom_range(99) < 75) ? 7'(60 + $urandom_range(7))
                                             : 7'($urandom_range(127));
            tag = ($urandom_range(99) < 70) ? 16'($urandom_range(15))
                                            : 16'($urandom_range(65535));
            vel = ($urandom_range(99) < 8) ? 7'd0 : 7'($urandom_range(1, 127));
            bend = ($urandom_range(99) < 15);
            send_word(kind, note, tag, vel, bend, 4'($urandom_range(15)));
            sent++;
        end
    endtask

    initial begin
        stamp_counter = '0;
        for (int v = 0; v < NUM_VOICES; v++) begin
            voice_on[v] = 1'b0;
            voice_held[v] = 1'b0;
            voice_note[v] = '0;
            voice_ident[v] = '0;
            voice_vel[v] = '0;
            voice_age[v] = '0;
        end
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_ignored_words();
        test_fill_and_steal();
        test_release_and_finish();
        wait_drained();
        test_random_traffic(500);
        wait_drained();
        steady_flow = 1'b1;
        test_random_traffic(250);
        wait_drained();
        steady_flow = 1'b0;
        test_random_traffic(500);
        wait_drained();

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
